@@ sv/pls_pkg.sv @@
// Shared types, constants and helper functions for the parabolic line search.
`timescale 1ns / 1ps
package pls_pkg;

    localparam int VALUE_BITS_DEF    = 48;
    localparam int FRACTION_BITS_DEF = 24;
    localparam int CFG_BITS          = 47;
    localparam int CFG_ADDR_BITS     = 5;

    localparam logic [CFG_BITS-1:0] BRACKET_TOL_RESET = 47'd1678;
    localparam logic [CFG_BITS-1:0] CURV_TOL_RESET    = 47'd0;
    localparam logic [CFG_BITS-1:0] FLAT_THR_RESET    = 47'd1;

    // Register byte addresses (47-bit registers on 64-bit data, 8 bytes apart)
    localparam logic [CFG_ADDR_BITS-1:0] ADDR_BRACKET_TOL = 5'd0;
    localparam logic [CFG_ADDR_BITS-1:0] ADDR_CURV_TOL    = 5'd8;
    localparam logic [CFG_ADDR_BITS-1:0] ADDR_FLAT_THR    = 5'd16;

    // Result codes
    localparam logic [1:0] RK_EVAL    = 2'd0;
    localparam logic [1:0] RK_DONE    = 2'd1;
    localparam logic [1:0] RK_IGNORED = 2'd2;

    // Search phase
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_MID    = 3'd1,
        PH_LEFT   = 3'd2,
        PH_RIGHT  = 3'd3,
        PH_CAND   = 3'd4,
        PH_BISECT = 3'd5
    } phase_t;

    // Controller state
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_DEN,
        ST_DEN_CHECK,
        ST_NUM,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_VERTEX,
        ST_OUT
    } ctrl_state_t;

    // Datapath commands
    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_LOAD_MID,
        OP_LOAD_LEFT,
        OP_LOAD_RIGHT,
        OP_CANDIDATE,
        OP_LOAD_BISECT,
        OP_DEN,
        OP_NUM,
        OP_DIV,
        OP_VERTEX,
        OP_IGNORE,
        OP_DONE
    } dp_op_t;

    // Datapath command bundle
    typedef struct packed {
        dp_op_t op;
        logic   seq_go;
    } dp_cmd_t;

    // Datapath status bundle
    typedef struct packed {
        logic seq_busy;
        logic stop;
        logic bisect;
    } dp_stat_t;

endpackage

@@ sv/parabolic_line_search_safeguarded.sv @@
// Top level of the safeguarded parabolic line search with its register port.
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_stall   | kind, start_left/middle/right, func_value
//   out     | output    | out_valid/out_stall | result_kind, point, best_value
//   cfg     | input     | APB psel/penable    | three 47-bit thresholds, 64-bit data
// Start items, the first two values and ignored values raise the result at the
// accepting edge; a bisection request raises it after the dispatch state that follows
// the candidate answer. A value that closes a step raises it after the dispatch state
// (for a candidate answer), three products for den, six for num and a one-bit-per-cycle
// divide (VALUE+FRACTION bits); if the search stops, the num products and divide are skipped.
// Reset clears the phase, the bracket and the thresholds to their defaults.
// A new item is taken only once the previous result is taken, at the same edge at best.
`timescale 1ns / 1ps
module parabolic_line_search_safeguarded #(
    parameter int VALUE_BITS    = pls_pkg::VALUE_BITS_DEF,
    parameter int FRACTION_BITS = pls_pkg::FRACTION_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  kind,
    input  logic signed [VALUE_BITS-1:0]          start_left,
    input  logic signed [VALUE_BITS-1:0]          start_middle,
    input  logic signed [VALUE_BITS-1:0]          start_right,
    input  logic signed [VALUE_BITS-1:0]          func_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [1:0]                            result_kind,
    output logic signed [VALUE_BITS-1:0]          point,
    output logic signed [VALUE_BITS-1:0]          best_value,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [pls_pkg::CFG_ADDR_BITS-1:0]     paddr,
    input  logic [63:0]                           pwdata,
    output logic [63:0]                           prdata,
    output logic                                  pready
);

    logic [pls_pkg::CFG_BITS-1:0] btol_reg, ctol_reg, flat_reg;
    logic [pls_pkg::CFG_ADDR_BITS-1:0] addr_lo;
    pls_pkg::dp_cmd_t  cmd;
    pls_pkg::dp_stat_t stat;

    assign pready  = 1'b1;
    assign addr_lo = paddr;

    // Register writes (64-bit data: low bits carry the register)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            btol_reg <= pls_pkg::BRACKET_TOL_RESET;
            ctol_reg <= pls_pkg::CURV_TOL_RESET;
            flat_reg <= pls_pkg::FLAT_THR_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (addr_lo)
                pls_pkg::ADDR_BRACKET_TOL: btol_reg <= pwdata[pls_pkg::CFG_BITS-1:0];
                pls_pkg::ADDR_CURV_TOL:    ctol_reg <= pwdata[pls_pkg::CFG_BITS-1:0];
                pls_pkg::ADDR_FLAT_THR:    flat_reg <= pwdata[pls_pkg::CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (addr_lo)
            pls_pkg::ADDR_BRACKET_TOL: prdata = 64'(btol_reg);
            pls_pkg::ADDR_CURV_TOL:    prdata = 64'(ctol_reg);
            pls_pkg::ADDR_FLAT_THR:    prdata = 64'(flat_reg);
            default:                   prdata = '0;
        endcase
    end

    pls_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_kind(kind), .out_valid(out_valid), .out_stall(out_stall),
        .cmd(cmd), .stat(stat)
    );

    pls_datapath #(.VALUE_BITS(VALUE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_left(start_left), .in_middle(start_middle), .in_right(start_right),
        .in_value(func_value), .bracket_tol(btol_reg), .curv_tol(ctol_reg),
        .flat_thr(flat_reg), .res_kind(result_kind), .res_point(point),
        .res_value(best_value)
    );

endmodule

@@ sv/pls_mul_seq.sv @@
// Sequenced saturating fixed-point multiply-accumulate unit for den and num sums.
`timescale 1ns / 1ps
module pls_mul_seq #(
    parameter int VALUE_BITS    = pls_pkg::VALUE_BITS_DEF,
    parameter int FRACTION_BITS = pls_pkg::FRACTION_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         go,
    input  logic                         use_squares,
    input  logic signed [VALUE_BITS-1:0] xl,
    input  logic signed [VALUE_BITS-1:0] xm,
    input  logic signed [VALUE_BITS-1:0] xr,
    input  logic signed [VALUE_BITS-1:0] fl,
    input  logic signed [VALUE_BITS-1:0] fm,
    input  logic signed [VALUE_BITS-1:0] fr,
    output logic                         busy,
    output logic signed [VALUE_BITS-1:0] sum
);

    localparam int HW = (VALUE_BITS + 1) / 2;
    localparam int PW = 2 * VALUE_BITS;
    localparam logic signed [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    // Steps: square l,m,r (optional), then three products accumulated.
    // Each product is accumulated from four partial products of HW x HW bits.
    typedef enum logic [2:0] {
        MS_IDLE, MS_SETUP, MS_PP, MS_FINISH
    } mstate_t;

    mstate_t                  st_reg, st_next;
    logic [2:0]               job_reg, job_next;
    logic [1:0]               pp_reg, pp_next;
    logic                     sq_reg, sq_next;
    logic [VALUE_BITS-1:0]    ma_reg, mb_reg;
    logic                     neg_reg;
    logic [PW-1:0]            acc_reg;
    logic signed [VALUE_BITS-1:0] sl_reg, sm_reg, sr_reg, sum_reg;
    logic signed [VALUE_BITS-1:0] opa, opb;

    function automatic logic signed [VALUE_BITS-1:0] sadd(
        input logic signed [VALUE_BITS-1:0] a,
        input logic signed [VALUE_BITS-1:0] b
    );
        logic signed [VALUE_BITS:0] s;
        s = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
        if (s[VALUE_BITS] != s[VALUE_BITS-1])
            return s[VALUE_BITS] ? VMIN : VMAX;
        return s[VALUE_BITS-1:0];
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] ssub(
        input logic signed [VALUE_BITS-1:0] a,
        input logic signed [VALUE_BITS-1:0] b
    );
        logic signed [VALUE_BITS:0] s;
        s = {a[VALUE_BITS-1], a} - {b[VALUE_BITS-1], b};
        if (s[VALUE_BITS] != s[VALUE_BITS-1])
            return s[VALUE_BITS] ? VMIN : VMAX;
        return s[VALUE_BITS-1:0];
    endfunction

    function automatic logic [VALUE_BITS-1:0] vmag(input logic signed [VALUE_BITS-1:0] v);
        return v[VALUE_BITS-1] ? (~v + 1'b1) : v;
    endfunction

    // Select the operands of the current job
    always_comb
    begin
        opa = '0;
        opb = '0;
        case (job_reg)
            3'd0: begin opa = xl; opb = xl; end
            3'd1: begin opa = xm; opb = xm; end
            3'd2: begin opa = xr; opb = xr; end
            3'd3: begin
                opa = fr;
                opb = sq_reg ? ssub(sm_reg, sl_reg) : ssub(xm, xl);
            end
            3'd4: begin
                opa = fm;
                opb = sq_reg ? ssub(sl_reg, sr_reg) : ssub(xl, xr);
            end
            3'd5: begin
                opa = fl;
                opb = sq_reg ? ssub(sr_reg, sm_reg) : ssub(xr, xm);
            end
            default: begin opa = '0; opb = '0; end
        endcase
    end

    // Partial product for the current quarter
    logic [HW-1:0]   pa, pb;
    logic [2*HW-1:0] pp;
    logic [PW+1:0]   pp_sh;
    always_comb
    begin
        pa = pp_reg[0] ? HW'(ma_reg >> HW) : ma_reg[HW-1:0];
        pb = pp_reg[1] ? HW'(mb_reg >> HW) : mb_reg[HW-1:0];
        pp = pa * pb;
        pp_sh = (PW+2)'(pp) << (HW * (32'(pp_reg[0]) + 32'(pp_reg[1])));
    end

    // Saturate the finished product
    logic [PW-1:0]                 shifted;
    logic                          ovf;
    logic signed [VALUE_BITS-1:0]  prod;
    always_comb
    begin
        shifted = acc_reg >> FRACTION_BITS;
        ovf = neg_reg ? (shifted > PW'({1'b1, {(VALUE_BITS-1){1'b0}}}))
                      : (shifted > PW'(VMAX));
        if (ovf)
            prod = neg_reg ? VMIN : VMAX;
        else
            prod = neg_reg ? -$signed(shifted[VALUE_BITS-1:0]) : $signed(shifted[VALUE_BITS-1:0]);
    end

    always_comb
    begin
        st_next  = st_reg;
        job_next = job_reg;
        pp_next  = pp_reg;
        sq_next  = sq_reg;
        case (st_reg)
            MS_IDLE:
                if (go)
                begin
                    sq_next  = use_squares;
                    job_next = use_squares ? 3'd0 : 3'd3;
                    st_next  = MS_SETUP;
                end
            MS_SETUP:
            begin
                pp_next = 2'd0;
                st_next = MS_PP;
            end
            MS_PP:
                if (pp_reg == 2'd3)
                    st_next = MS_FINISH;
                else
                    pp_next = pp_reg + 2'd1;
            MS_FINISH:
                if (job_reg == 3'd5)
                    st_next = MS_IDLE;
                else
                begin
                    job_next = job_reg + 3'd1;
                    st_next  = MS_SETUP;
                end
            default: st_next = MS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= MS_IDLE;
            job_reg <= '0;
            pp_reg  <= '0;
            sq_reg  <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            job_reg <= job_next;
            pp_reg  <= pp_next;
            sq_reg  <= sq_next;
        end
    end

    // Datapath registers of the multiplier
    always_ff @(posedge clk)
    begin
        case (st_reg)
            MS_IDLE:
                if (go)
                    sum_reg <= '0;
            MS_SETUP:
            begin
                ma_reg  <= vmag(opa);
                mb_reg  <= vmag(opb);
                neg_reg <= opa[VALUE_BITS-1] ^ opb[VALUE_BITS-1];
                acc_reg <= '0;
            end
            MS_PP:
                acc_reg <= acc_reg + PW'(pp_sh);
            MS_FINISH:
                case (job_reg)
                    3'd0: sl_reg <= prod;
                    3'd1: sm_reg <= prod;
                    3'd2: sr_reg <= prod;
                    default: sum_reg <= sadd(sum_reg, prod);
                endcase
            default: ;
        endcase
    end

    assign busy = (st_reg != MS_IDLE);
    assign sum  = sum_reg;

endmodule

@@ sv/pls_div.sv @@
// Restoring divider for the saturating fixed-point quotient, one bit per cycle.
`timescale 1ns / 1ps
module pls_div #(
    parameter int VALUE_BITS    = pls_pkg::VALUE_BITS_DEF,
    parameter int FRACTION_BITS = pls_pkg::FRACTION_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         go,
    input  logic signed [VALUE_BITS-1:0] num,
    input  logic signed [VALUE_BITS-1:0] den,
    output logic                         busy,
    output logic signed [VALUE_BITS-1:0] quo
);

    localparam int NB = VALUE_BITS + FRACTION_BITS;
    localparam int CW = $clog2(NB + 1);
    localparam logic signed [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    logic                  busy_reg;
    logic [CW-1:0]         cnt_reg;
    logic [NB-1:0]         dvd_reg;
    logic [VALUE_BITS:0]   rem_reg;
    logic [VALUE_BITS-1:0] d_reg;
    logic [NB-1:0]         q_reg;
    logic                  neg_reg, nneg_reg, dz_reg;
    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS:0]   rem_sh;

    always_comb
    begin
        rem_sh = {rem_reg[VALUE_BITS-1:0], dvd_reg[NB-1]};
        trial  = rem_sh - {1'b0, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (go)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NB);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_reg <= 1'b0;
        end
    end

    // Shift one dividend bit per cycle
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            dvd_reg  <= NB'(num[VALUE_BITS-1] ? (~num + 1'b1) : num) << FRACTION_BITS;
            d_reg    <= den[VALUE_BITS-1] ? (~den + 1'b1) : den;
            rem_reg  <= '0;
            q_reg    <= '0;
            neg_reg  <= num[VALUE_BITS-1] ^ den[VALUE_BITS-1];
            nneg_reg <= num[VALUE_BITS-1];
            dz_reg   <= (den == '0);
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            if (!trial[VALUE_BITS])
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[NB-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[NB-2:0], 1'b0};
            end
        end
    end

    // Saturate the quotient
    always_comb
    begin
        if (dz_reg)
            quo = nneg_reg ? VMIN : VMAX;
        else if (neg_reg)
            quo = (q_reg > NB'({1'b1, {(VALUE_BITS-1){1'b0}}})) ? VMIN
                  : -$signed(q_reg[VALUE_BITS-1:0]);
        else
            quo = (q_reg > NB'(VMAX)) ? VMAX : $signed(q_reg[VALUE_BITS-1:0]);
    end

    assign busy = busy_reg;

endmodule

@@ sv/pls_datapath.sv @@
// Bracket registers, parabola arithmetic and result register of the search.
`timescale 1ns / 1ps
module pls_datapath #(
    parameter int VALUE_BITS    = pls_pkg::VALUE_BITS_DEF,
    parameter int FRACTION_BITS = pls_pkg::FRACTION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pls_pkg::dp_cmd_t                    cmd,
    output pls_pkg::dp_stat_t                   stat,
    input  logic signed [VALUE_BITS-1:0]        in_left,
    input  logic signed [VALUE_BITS-1:0]        in_middle,
    input  logic signed [VALUE_BITS-1:0]        in_right,
    input  logic signed [VALUE_BITS-1:0]        in_value,
    input  logic [pls_pkg::CFG_BITS-1:0]        bracket_tol,
    input  logic [pls_pkg::CFG_BITS-1:0]        curv_tol,
    input  logic [pls_pkg::CFG_BITS-1:0]        flat_thr,
    output logic [1:0]                          res_kind,
    output logic signed [VALUE_BITS-1:0]        res_point,
    output logic signed [VALUE_BITS-1:0]        res_value
);

    logic signed [VALUE_BITS-1:0] xl_reg, xm_reg, xr_reg, fl_reg, fm_reg, fr_reg, cx_reg;
    logic signed [VALUE_BITS-1:0] den_reg, num_reg, vtx;
    logic [1:0]                   rk_reg;
    logic signed [VALUE_BITS-1:0] rp_reg, rv_reg;
    logic                         stop_reg, bisect_reg;
    logic                         mul_busy, div_busy, mul_go, div_go;
    logic signed [VALUE_BITS-1:0] mul_sum, quo;

    assign mul_go = cmd.seq_go && (cmd.op == pls_pkg::OP_DEN || cmd.op == pls_pkg::OP_NUM);
    assign div_go = cmd.seq_go && (cmd.op == pls_pkg::OP_DIV);

    pls_mul_seq #(.VALUE_BITS(VALUE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_mul (
        .clk(clk), .rst_n(rst_n), .go(mul_go), .use_squares(cmd.op == pls_pkg::OP_NUM),
        .xl(xl_reg), .xm(xm_reg), .xr(xr_reg), .fl(fl_reg), .fm(fm_reg), .fr(fr_reg),
        .busy(mul_busy), .sum(mul_sum)
    );

    pls_div #(.VALUE_BITS(VALUE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .go(div_go), .num(num_reg), .den(den_reg),
        .busy(div_busy), .quo(quo)
    );

    function automatic logic signed [VALUE_BITS-1:0] halve(input logic signed [VALUE_BITS-1:0] v);
        return v >>> 1;
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] midpt(
        input logic signed [VALUE_BITS-1:0] p,
        input logic signed [VALUE_BITS-1:0] q
    );
        logic signed [VALUE_BITS:0] s;
        s = {p[VALUE_BITS-1], p} + {q[VALUE_BITS-1], q};
        return s[VALUE_BITS:1];
    endfunction

    function automatic logic [VALUE_BITS:0] adiff(
        input logic signed [VALUE_BITS-1:0] a,
        input logic signed [VALUE_BITS-1:0] b
    );
        logic signed [VALUE_BITS:0] d;
        d = {a[VALUE_BITS-1], a} - {b[VALUE_BITS-1], b};
        return d[VALUE_BITS] ? (~d + 1'b1) : d;
    endfunction

    // Vertex from the quotient, with the flat and degenerate fallbacks
    logic [VALUE_BITS:0] num_mag;
    always_comb
    begin
        num_mag = adiff(num_reg, '0);
        vtx = (num_mag < (VALUE_BITS+1)'(flat_thr)) ? '0 : halve(quo);
        if (vtx == xm_reg)
            vtx = midpt(xm_reg, xl_reg);
    end

    logic [VALUE_BITS:0] fdiff;
    assign fdiff = adiff(fm_reg, in_value);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xl_reg <= '0; xm_reg <= '0; xr_reg <= '0;
            fl_reg <= '0; fm_reg <= '0; fr_reg <= '0;
            cx_reg <= '0;
        end
        else
        begin
            case (cmd.op)
                pls_pkg::OP_START:
                begin
                    xl_reg <= in_left; xm_reg <= in_middle; xr_reg <= in_right;
                end
                pls_pkg::OP_LOAD_MID:    fm_reg <= in_value;
                pls_pkg::OP_LOAD_LEFT:   fl_reg <= in_value;
                pls_pkg::OP_LOAD_RIGHT:  fr_reg <= in_value;
                pls_pkg::OP_LOAD_BISECT: fm_reg <= in_value;
                pls_pkg::OP_CANDIDATE:
                    if (fdiff < (VALUE_BITS+1)'(flat_thr))
                    begin
                        if (xm_reg < cx_reg)
                        begin
                            xl_reg <= xm_reg; fl_reg <= fm_reg;
                            xr_reg <= cx_reg; fr_reg <= in_value;
                            xm_reg <= midpt(xm_reg, cx_reg);
                        end
                        else if (xm_reg > cx_reg)
                        begin
                            xl_reg <= cx_reg; fl_reg <= in_value;
                            xr_reg <= xm_reg; fr_reg <= fm_reg;
                            xm_reg <= midpt(cx_reg, xm_reg);
                        end
                    end
                    else if (fm_reg > in_value)
                    begin
                        if (xm_reg < cx_reg)
                        begin
                            xl_reg <= xm_reg; fl_reg <= fm_reg;
                        end
                        else
                        begin
                            xr_reg <= xm_reg; fr_reg <= fm_reg;
                        end
                        xm_reg <= cx_reg; fm_reg <= in_value;
                    end
                    else if (xm_reg < cx_reg)
                    begin
                        xr_reg <= cx_reg; fr_reg <= in_value;
                    end
                    else
                    begin
                        xl_reg <= cx_reg; fl_reg <= in_value;
                    end
                pls_pkg::OP_VERTEX: cx_reg <= vtx;
                default: ;
            endcase
        end
    end

    // Bisect flag (held for the dispatch cycle only), stop test
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bisect_reg <= 1'b0;
            stop_reg   <= 1'b0;
        end
        else
        begin
            bisect_reg <= (cmd.op == pls_pkg::OP_CANDIDATE)
                          && (fdiff < (VALUE_BITS+1)'(flat_thr)) && (xm_reg != cx_reg);
            if (cmd.op == pls_pkg::OP_DEN && !cmd.seq_go)
                stop_reg <= (adiff(xl_reg, xr_reg) <= (VALUE_BITS+1)'(bracket_tol))
                            || mul_sum[VALUE_BITS-1]
                            || ((VALUE_BITS+1)'(unsigned'(mul_sum)) < (VALUE_BITS+1)'(curv_tol));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == pls_pkg::OP_DEN && !cmd.seq_go)
            den_reg <= mul_sum;
        if (cmd.op == pls_pkg::OP_NUM && !cmd.seq_go)
            num_reg <= mul_sum;
    end

    // Result register
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            pls_pkg::OP_START:
            begin
                rk_reg <= pls_pkg::RK_EVAL; rp_reg <= in_middle; rv_reg <= '0;
            end
            pls_pkg::OP_LOAD_MID:
            begin
                rk_reg <= pls_pkg::RK_EVAL; rp_reg <= xl_reg; rv_reg <= '0;
            end
            pls_pkg::OP_LOAD_LEFT:
            begin
                rk_reg <= pls_pkg::RK_EVAL; rp_reg <= xr_reg; rv_reg <= '0;
            end
            pls_pkg::OP_IGNORE:
            begin
                rk_reg <= pls_pkg::RK_IGNORED; rp_reg <= '0; rv_reg <= '0;
            end
            pls_pkg::OP_DONE:
            begin
                rk_reg <= pls_pkg::RK_DONE; rp_reg <= xm_reg; rv_reg <= fm_reg;
            end
            pls_pkg::OP_VERTEX:
            begin
                rk_reg <= pls_pkg::RK_EVAL; rp_reg <= vtx; rv_reg <= '0;
            end
            pls_pkg::OP_NONE:
                if (bisect_reg)
                begin
                    rk_reg <= pls_pkg::RK_EVAL; rp_reg <= xm_reg; rv_reg <= '0;
                end
            default: ;
        endcase
    end

    assign stat.seq_busy = mul_busy || div_busy;
    assign stat.stop     = stop_reg;
    assign stat.bisect   = bisect_reg;
    assign res_kind  = rk_reg;
    assign res_point = rp_reg;
    assign res_value = rv_reg;

endmodule

@@ sv/pls_ctrl.sv @@
// Controller state machine: phase tracking, step sequencing and handshakes.
`timescale 1ns / 1ps
module pls_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                in_kind,
    output logic                out_valid,
    input  logic                out_stall,
    output pls_pkg::dp_cmd_t    cmd,
    input  pls_pkg::dp_stat_t   stat
);

    pls_pkg::ctrl_state_t st_reg, st_next;
    pls_pkg::phase_t      ph_reg, ph_next;
    logic                 ov_reg, ov_next;
    logic                 accept;

    assign in_stall = (st_reg != pls_pkg::ST_IDLE) || (ov_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= pls_pkg::ST_IDLE;
            ph_reg   <= pls_pkg::PH_IDLE;
            ov_reg   <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            ph_reg   <= ph_next;
            ov_reg   <= ov_next;
        end
    end

    always_comb
    begin
        st_next    = st_reg;
        ph_next    = ph_reg;
        ov_next    = ov_reg && out_stall;
        cmd.op     = pls_pkg::OP_NONE;
        cmd.seq_go = 1'b0;
        case (st_reg)
            pls_pkg::ST_IDLE:
                if (accept)
                begin
                    if (!in_kind)
                    begin
                        cmd.op  = pls_pkg::OP_START;
                        ph_next = pls_pkg::PH_MID;
                        ov_next = 1'b1;
                    end
                    else
                        case (ph_reg)
                            pls_pkg::PH_MID:
                            begin
                                cmd.op = pls_pkg::OP_LOAD_MID;
                                ph_next = pls_pkg::PH_LEFT;
                                ov_next = 1'b1;
                            end
                            pls_pkg::PH_LEFT:
                            begin
                                cmd.op = pls_pkg::OP_LOAD_LEFT;
                                ph_next = pls_pkg::PH_RIGHT;
                                ov_next = 1'b1;
                            end
                            pls_pkg::PH_RIGHT:
                            begin
                                cmd.op = pls_pkg::OP_LOAD_RIGHT;
                                st_next = pls_pkg::ST_DEN;
                            end
                            pls_pkg::PH_CAND:
                            begin
                                cmd.op = pls_pkg::OP_CANDIDATE;
                                st_next = pls_pkg::ST_DISPATCH;
                            end
                            pls_pkg::PH_BISECT:
                            begin
                                cmd.op = pls_pkg::OP_LOAD_BISECT;
                                st_next = pls_pkg::ST_DEN;
                            end
                            default:
                            begin
                                cmd.op = pls_pkg::OP_IGNORE;
                                ph_next = pls_pkg::PH_IDLE;
                                ov_next = 1'b1;
                            end
                        endcase
                end
            // After a candidate answer: bisect request or a fresh iteration
            pls_pkg::ST_DISPATCH:
                if (stat.bisect)
                begin
                    ph_next = pls_pkg::PH_BISECT;
                    ov_next = 1'b1;
                    st_next = pls_pkg::ST_IDLE;
                end
                else
                    st_next = pls_pkg::ST_DEN;
            pls_pkg::ST_DEN:
            begin
                cmd.op = pls_pkg::OP_DEN;
                cmd.seq_go = 1'b1;
                st_next = pls_pkg::ST_DEN_CHECK;
            end
            pls_pkg::ST_DEN_CHECK:
                if (!stat.seq_busy)
                begin
                    cmd.op = pls_pkg::OP_DEN;
                    st_next = pls_pkg::ST_NUM;
                end
            pls_pkg::ST_NUM:
                if (stat.stop)
                begin
                    cmd.op = pls_pkg::OP_DONE;
                    ph_next = pls_pkg::PH_IDLE;
                    ov_next = 1'b1;
                    st_next = pls_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.op = pls_pkg::OP_NUM;
                    cmd.seq_go = 1'b1;
                    st_next = pls_pkg::ST_DIV_START;
                end
            pls_pkg::ST_DIV_START:
                if (!stat.seq_busy)
                begin
                    cmd.op = pls_pkg::OP_NUM;
                    st_next = pls_pkg::ST_DIV_WAIT;
                end
            pls_pkg::ST_DIV_WAIT:
            begin
                cmd.op = pls_pkg::OP_DIV;
                cmd.seq_go = 1'b1;
                st_next = pls_pkg::ST_VERTEX;
            end
            pls_pkg::ST_VERTEX:
                if (!stat.seq_busy)
                begin
                    cmd.op = pls_pkg::OP_VERTEX;
                    ph_next = pls_pkg::PH_CAND;
                    ov_next = 1'b1;
                    st_next = pls_pkg::ST_IDLE;
                end
            default: st_next = pls_pkg::ST_IDLE;
        endcase
    end

    assign out_valid = ov_reg;

    // Only one transaction in flight
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != pls_pkg::ST_IDLE) |-> !accept)
        else $error("input accepted while a step is in progress");
    a_result_on_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_next && !ov_reg) |-> (st_next == pls_pkg::ST_IDLE))
        else $error("result raised while the controller stays busy");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> ov_reg)
        else $error("stalled result dropped");

endmodule

@@ tb/parabolic_line_search_safeguarded_tb.sv @@
// Testbench for the safeguarded parabolic line search: predictor, driver and checker.
`timescale 1ns / 1ps
module parabolic_line_search_safeguarded_tb;

    localparam longint VAL_MAX = (64'sd1 <<< 47) - 1;
    localparam longint VAL_MIN = -VAL_MAX - 1;
    localparam longint ONE     = 64'sd1 <<< 24;
    localparam logic [63:0] CFG_MASK = 64'h0000_7FFF_FFFF_FFFF;

    typedef struct {
        logic [1:0] rkind;
        longint     pt;
        longint     best;
    } search_result_t;

    typedef struct {
        longint amp;
        longint ctr;
        longint offs;
    } bowl_t;

    logic              clk = 0;
    logic              rst_n = 0;
    logic              in_valid = 0;
    logic              in_stall;
    logic              kind = 0;
    logic signed [47:0] start_left = 0;
    logic signed [47:0] start_middle = 0;
    logic signed [47:0] start_right = 0;
    logic signed [47:0] func_value = 0;
    logic              out_valid;
    logic              out_stall = 0;
    logic [1:0]        result_kind;
    logic signed [47:0] point;
    logic signed [47:0] best_value;
    logic              psel = 0;
    logic              penable = 0;
    logic              pwrite = 0;
    logic [pls_pkg::CFG_ADDR_BITS-1:0] paddr = '0;
    logic [63:0]       pwdata = 0;
    logic [63:0]       prdata;
    logic              pready;

    // Predictor state and configuration copy
    longint  br_l, br_m, br_r, val_l, val_m, val_r, cand;
    pls_pkg::phase_t srch_phase;
    longint  bracket_tol, curv_tol, flat_thr;

    search_result_t expected_results[$];
    int  errors = 0;
    bit  quiet = 0;
    int  stall_left = 0;

    parabolic_line_search_safeguarded dut (.*);

    always #2 clk = ~clk;

    // Saturate a sign and magnitude to the value format
    function automatic longint clamp(bit neg, logic [63:0] m);
        if (neg) return (m >= 64'h0000_8000_0000_0000) ? VAL_MIN : -longint'(m);
        return (m > 64'h0000_7FFF_FFFF_FFFF) ? VAL_MAX : longint'(m);
    endfunction

    function automatic logic [63:0] magn(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint q_add(longint a, longint b);
        longint s;
        s = a + b;
        return (s > VAL_MAX) ? VAL_MAX : (s < VAL_MIN) ? VAL_MIN : s;
    endfunction

    function automatic longint q_sub(longint a, longint b);
        longint s;
        s = a - b;
        return (s > VAL_MAX) ? VAL_MAX : (s < VAL_MIN) ? VAL_MIN : s;
    endfunction

    function automatic longint q_mul(longint a, longint b);
        logic [127:0] p;
        p = {64'd0, magn(a)} * {64'd0, magn(b)};
        p = p >> 24;
        return clamp((a < 0) != (b < 0), (p[127:64] != 0) ? '1 : p[63:0]);
    endfunction

    function automatic longint q_div(longint a, longint b);
        logic [127:0] n, q;
        if (b == 0) return clamp(a < 0, '1);
        n = {64'd0, magn(a)} << 24;
        q = n / {64'd0, magn(b)};
        return clamp((a < 0) != (b < 0), (q > 128'h8000_0000_0000) ? '1 : q[63:0]);
    endfunction

    function automatic longint avg_floor(longint p, longint q);
        return (p + q) >>> 1;
    endfunction

    // One narrowing step: stop test, then vertex request
    function automatic search_result_t fit_step();
        longint den, num, sl, sm, sr, xb, w;
        search_result_t r;
        den = q_add(q_add(q_mul(val_r, q_sub(br_m, br_l)), q_mul(val_m, q_sub(br_l, br_r))),
                    q_mul(val_l, q_sub(br_r, br_m)));
        w = br_l - br_r;
        if (w < 0) w = -w;
        if (w <= bracket_tol || den < 0 || den < curv_tol) begin
            srch_phase = pls_pkg::PH_IDLE;
            r = '{pls_pkg::RK_DONE, br_m, val_m};
            return r;
        end
        sl = q_mul(br_l, br_l);
        sm = q_mul(br_m, br_m);
        sr = q_mul(br_r, br_r);
        num = q_add(q_add(q_mul(val_r, q_sub(sm, sl)), q_mul(val_m, q_sub(sl, sr))),
                    q_mul(val_l, q_sub(sr, sm)));
        xb = (magn(num) < flat_thr) ? 0 : (q_div(num, den) >>> 1);
        if (xb == br_m) xb = avg_floor(br_m, br_l);
        cand = xb;
        srch_phase = pls_pkg::PH_CAND;
        r = '{pls_pkg::RK_EVAL, xb, 0};
        return r;
    endfunction

    function automatic search_result_t predict_search(logic k, longint l, longint m,
                                                      longint rt, longint v);
        search_result_t r;
        longint d;
        r = '{pls_pkg::RK_EVAL, 0, 0};
        if (k == 1'b0) begin
            br_l = l; br_m = m; br_r = rt;
            srch_phase = pls_pkg::PH_MID;
            r.pt = m;
            return r;
        end
        case (srch_phase)
            pls_pkg::PH_MID: begin
                val_m = v; srch_phase = pls_pkg::PH_LEFT; r.pt = br_l;
            end
            pls_pkg::PH_LEFT: begin
                val_l = v; srch_phase = pls_pkg::PH_RIGHT; r.pt = br_r;
            end
            pls_pkg::PH_RIGHT: begin
                val_r = v; r = fit_step();
            end
            pls_pkg::PH_BISECT: begin
                val_m = v; r = fit_step();
            end
            pls_pkg::PH_CAND: begin
                d = val_m - v;
                if (d < 0) d = -d;
                if (d < flat_thr) begin
                    if (br_m != cand) begin
                        if (br_m < cand) begin
                            br_l = br_m; val_l = val_m; br_r = cand; val_r = v;
                        end
                        else begin
                            br_l = cand; val_l = v; br_r = br_m; val_r = val_m;
                        end
                        br_m = avg_floor(br_l, br_r);
                        srch_phase = pls_pkg::PH_BISECT;
                        r.pt = br_m;
                        return r;
                    end
                end
                else if (val_m > v) begin
                    if (br_m < cand) begin
                        br_l = br_m; val_l = val_m;
                    end
                    else begin
                        br_r = br_m; val_r = val_m;
                    end
                    br_m = cand; val_m = v;
                end
                else if (br_m < cand) begin
                    br_r = cand; val_r = v;
                end
                else begin
                    br_l = cand; val_l = v;
                end
                r = fit_step();
            end
            default: begin
                srch_phase = pls_pkg::PH_IDLE;
                r = '{pls_pkg::RK_IGNORED, 0, 0};
            end
        endcase
        return r;
    endfunction

    function automatic longint bowl_value(bowl_t b, longint x);
        longint d;
        d = q_sub(x, b.ctr);
        return q_add(q_mul(b.amp, q_mul(d, d)), b.offs);
    endfunction

    function automatic longint rand_val48();
        return longint'({$urandom, $urandom}) <<< 16 >>> 16;
    endfunction

    // Drive one transaction and record its expected result
    task automatic send_item(input logic k, input longint l, input longint m,
                             input longint rt, input longint v, output search_result_t r);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            @(negedge clk);
            in_valid <= 0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        else begin
            @(negedge clk);
        end
        in_valid     <= 1;
        kind         <= k;
        start_left   <= l[47:0];
        start_middle <= m[47:0];
        start_right  <= rt[47:0];
        func_value   <= v[47:0];
        r = predict_search(k, l, m, rt, v);
        do @(posedge clk); while (in_stall);
        expected_results.push_back(r);
    endtask

    // Start a search and answer its requests from a bowl-shaped function
    task automatic run_search(input bowl_t b, input longint l, input longint m,
                              input longint rt, input int max_steps, inout int count);
        search_result_t r;
        int n;
        send_item(1'b0, l, m, rt, rand_val48(), r);
        count++;
        n = 0;
        while (r.rkind == pls_pkg::RK_EVAL && n < max_steps) begin
            send_item(1'b1, rand_val48(), rand_val48(), rand_val48(), bowl_value(b, r.pt), r);
            count++;
            n++;
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 0;
        while (expected_results.size() != 0) @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [pls_pkg::CFG_ADDR_BITS-1:0] a, input logic [63:0] d);
        @(negedge clk);
        psel <= 1; pwrite <= 1; penable <= 0; paddr <= a; pwdata <= d;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (a == pls_pkg::ADDR_BRACKET_TOL) bracket_tol = longint'(d & CFG_MASK);
        else if (a == pls_pkg::ADDR_CURV_TOL) curv_tol = longint'(d & CFG_MASK);
        else flat_thr = longint'(d & CFG_MASK);
    endtask

    task automatic set_thresholds(input logic [63:0] bt, input logic [63:0] ct,
                                  input logic [63:0] ft);
        drain();
        cfg_write(pls_pkg::ADDR_BRACKET_TOL, bt);
        cfg_write(pls_pkg::ADDR_CURV_TOL, ct);
        cfg_write(pls_pkg::ADDR_FLAT_THR, ft);
    endtask

    task automatic test_directed();
        search_result_t r;
        bowl_t b;
        int c;
        c = 0;
        // Value while idle is ignored
        send_item(1'b1, 0, 0, 0, VAL_MAX, r);
        send_item(1'b1, 0, 0, 0, VAL_MIN, r);
        // Extreme start points, then abandon with a new start
        send_item(1'b0, VAL_MIN, VAL_MAX, VAL_MIN, 0, r);
        send_item(1'b1, 0, 0, 0, VAL_MAX, r);
        send_item(1'b0, VAL_MAX, VAL_MIN, VAL_MAX, 0, r);
        send_item(1'b1, 0, 0, 0, VAL_MIN, r);
        send_item(1'b1, 0, 0, 0, VAL_MAX, r);
        send_item(1'b1, 0, 0, 0, VAL_MIN, r);
        // Ordinary bowl, points in order
        b = '{ONE, 3 * ONE / 2, 0};
        run_search(b, -4 * ONE, ONE / 4, 5 * ONE, 20, c);
        // Points out of order
        run_search(b, 6 * ONE, -2 * ONE, ONE, 10, c);
        // Flat function: equal values drive the bisection path
        b = '{0, 0, 7 * ONE};
        run_search(b, -ONE, 0, 2 * ONE, 10, c);
        // Concave: negative curvature stops at once
        b = '{-ONE, 0, 0};
        run_search(b, -ONE, ONE / 3, ONE, 4, c);
    endtask

    task automatic test_random(input int target);
        bowl_t b;
        search_result_t r;
        longint l, m, rt, sp;
        int c;
        c = 0;
        while (c < target) begin
            case ($urandom_range(0, 9))
                0: begin
                    send_item(1'($urandom_range(0, 1)), rand_val48(), rand_val48(),
                              rand_val48(), rand_val48(), r);
                    c++;
                end
                1: begin
                    b = '{rand_val48(), rand_val48(), rand_val48()};
                    run_search(b, rand_val48(), rand_val48(), rand_val48(),
                               $urandom_range(0, 8), c);
                end
                default: begin
                    b.amp  = longint'($urandom_range(1, 64)) * (ONE / 16);
                    if ($urandom_range(0, 7) == 0) b.amp = 0;
                    if ($urandom_range(0, 15) == 0) b.amp = -b.amp;
                    b.ctr  = longint'($urandom_range(0, 32'h3FFF_FFFF)) - (64'sd1 <<< 29);
                    b.offs = longint'($urandom_range(0, 32'h0FFF_FFFF)) - (64'sd1 <<< 27);
                    sp = longint'($urandom_range(1, 32'h1FFF_FFFF));
                    l  = b.ctr - sp;
                    rt = b.ctr + longint'($urandom_range(1, 32'h1FFF_FFFF));
                    m  = l + longint'($urandom_range(0, 1000)) * ((rt - l) / 1000);
                    run_search(b, l, m, rt, $urandom_range(4, 40), c);
                end
            endcase
        end
    endtask

    // Receiver stall bursts
    always @(negedge clk) begin
        if (quiet) begin
            out_stall <= 0;
        end
        else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1;
        end
        else if ($urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 6);
            out_stall  <= 1;
        end
        else begin
            out_stall <= 0;
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk) begin
        search_result_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result kind %0d point %0d value %0d",
                         $time, result_kind, point, best_value);
                errors++;
            end
            else begin
                e = expected_results.pop_front();
                if (result_kind !== e.rkind) begin
                    $display("%0t: result_kind expected %0d actual %0d",
                             $time, e.rkind, result_kind);
                    errors++;
                end
                if (point !== e.pt[47:0]) begin
                    $display("%0t: point expected %0d actual %0d", $time,
                             $signed(e.pt[47:0]), point);
                    errors++;
                end
                if (best_value !== e.best[47:0]) begin
                    $display("%0t: best_value expected %0d actual %0d", $time,
                             $signed(e.best[47:0]), best_value);
                    errors++;
                end
            end
        end
    end

    initial begin
        br_l = 0; br_m = 0; br_r = 0; val_l = 0; val_m = 0; val_r = 0; cand = 0;
        srch_phase = pls_pkg::PH_IDLE;
        bracket_tol = 1678; curv_tol = 0; flat_thr = 1;
        repeat (6) @(negedge clk);
        rst_n = 1;
        test_directed();
        test_random(300);
        set_thresholds(0, 0, 0);
        test_random(250);
        set_thresholds(64'h7FFF_FFFF_FFFF, 0, 1);
        test_random(150);
        set_thresholds(1 << 16, 64'h0000_7FFF_FFFF_FFFF, 64'h0000_7FFF_FFFF_FFFF);
        test_random(200);
        set_thresholds(4096, 1 << 20, 1 << 12);
        test_random(400);
        set_thresholds(1678, 0, 1);
        test_random(250);
        quiet = 1;
        test_random(250);
        drain();
        if (errors == 0)
            $display("parabolic_line_search_safeguarded_tb: done, clean");
        else
            $display("parabolic_line_search_safeguarded_tb: done, errors");
        $finish;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("parabolic_line_search_safeguarded_tb: done, errors");
        $finish;
    end
endmodule
